[rtl/mi3_pkg.sv]
// shared constants and types for the 3x3 matrix inverse pipeline
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned Lanes    = 9;
  localparam int unsigned InW      = 32;
  localparam int unsigned CofW     = 65;
  localparam int unsigned DetW     = 98;
  localparam int unsigned RemW     = DetW + 33;
  localparam int unsigned QW       = 33;
  localparam int unsigned DivSteps = 33;
  localparam int unsigned PipeDepth = 2 + 4 + DivSteps + 1;

  // cofactor k = a[P]*a[Q] - a[R]*a[S]
  localparam logic [3:0] CofP [9] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam logic [3:0] CofQ [9] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam logic [3:0] CofR [9] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam logic [3:0] CofS [9] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  // divider pipeline payload
  typedef struct packed {
    logic [Lanes-1:0][RemW-1:0] rem;
    logic [Lanes-1:0][QW-1:0]   quo;
    logic [Lanes-1:0]           neg;
    logic [DetW-1:0]            dmag;
    logic                       sing;
    logic [InW-1:0]             det;
  } div_t;

endpackage

[rtl/mi3_cofactor.sv]
// two-stage cofactor unit: 18 products, then nine differences
`timescale 1ns / 1ps
module mi3_cofactor (
  input  logic                                         clk_i,
  input  logic                                         en_i,
  input  logic [8:0][mi3_pkg::InW-1:0]                 a_i,
  output logic [8:0][mi3_pkg::CofW-1:0]                cof_o,
  output logic [2:0][mi3_pkg::InW-1:0]                 row0_o
);

  logic signed [2*mi3_pkg::InW-1:0] pa_q [9];
  logic signed [2*mi3_pkg::InW-1:0] pb_q [9];
  logic [2:0][mi3_pkg::InW-1:0]     row0_q1, row0_q2;
  logic [8:0][mi3_pkg::CofW-1:0]    cof_q;

  // products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        pa_q[k] <= $signed(a_i[mi3_pkg::CofP[k]]) * $signed(a_i[mi3_pkg::CofQ[k]]);
        pb_q[k] <= $signed(a_i[mi3_pkg::CofR[k]]) * $signed(a_i[mi3_pkg::CofS[k]]);
      end
      row0_q1 <= a_i[2:0];
    end
  end

  // differences at full width
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        cof_q[k] <= {pa_q[k][2*mi3_pkg::InW-1], pa_q[k]}
                  - {pb_q[k][2*mi3_pkg::InW-1], pb_q[k]};
      end
      row0_q2 <= row0_q1;
    end
  end

  assign cof_o  = cof_q;
  assign row0_o = row0_q2;

endmodule

[rtl/mi3_det.sv]
// determinant from row 0 and cofactors, then divider operand setup
`timescale 1ns / 1ps
module mi3_det #(
  parameter int unsigned FRAC_BITS = mi3_pkg::FracBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [8:0][mi3_pkg::CofW-1:0]      cof_i,
  input  logic [2:0][mi3_pkg::InW-1:0]       row0_i,
  output mi3_pkg::div_t                      dv_o
);

  localparam int unsigned CW = mi3_pkg::CofW;
  localparam int unsigned DW = mi3_pkg::DetW;

  logic signed [CW-1:0]          ph_q [3];
  logic signed [CW-1:0]          pl_q [3];
  logic signed [DW-1:0]          term_q [3];
  logic signed [DW-1:0]          det_q;
  logic [8:0][CW-1:0]            cof3_q, cof4_q, cof5_q;
  mi3_pkg::div_t                 dv_d, dv_q;
  logic signed [DW-1:0]          dsh;
  logic [CW-1:0]                 cmag;

  // split 65x32 products into two narrow ones
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        ph_q[j] <= $signed(row0_i[j]) * $signed(cof_i[3*j][CW-1:32]);
        pl_q[j] <= $signed(row0_i[j]) * $signed({1'b0, cof_i[3*j][31:0]});
      end
      cof3_q <= cof_i;
    end
  end

  // recombine partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        term_q[j] <= (DW'(ph_q[j]) <<< 32) + DW'(pl_q[j]);
      end
      cof4_q <= cof3_q;
    end
  end

  // determinant sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q  <= term_q[0] + term_q[1] + term_q[2];
      cof5_q <= cof4_q;
    end
  end

  // magnitudes, signs and the saturated determinant output
  always_comb begin
    dv_d      = '0;
    dv_d.sing = (det_q == '0);
    dv_d.dmag = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    for (int k = 0; k < 9; k++) begin
      cmag = cof5_q[k][CW-1] ? (~cof5_q[k] + CW'(1)) : cof5_q[k];
      dv_d.rem[k] = mi3_pkg::RemW'(cmag) << (2 * FRAC_BITS);
      dv_d.neg[k] = cof5_q[k][CW-1] ^ det_q[DW-1];
    end
    dsh = det_q >>> (2 * FRAC_BITS);
    if ((&dsh[DW-1:31]) || !(|dsh[DW-1:31])) begin
      dv_d.det = dsh[31:0];
    end else begin
      dv_d.det = dsh[DW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q <= dv_d;
    end
  end

  assign dv_o = dv_q;

endmodule

[rtl/mi3_div_step.sv]
// one restoring division step for all nine lanes
`timescale 1ns / 1ps
module mi3_div_step #(
  parameter int unsigned SHIFT = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  mi3_pkg::div_t  dv_i,
  output mi3_pkg::div_t  dv_o
);

  mi3_pkg::div_t             dv_d, dv_q;
  logic [mi3_pkg::RemW-1:0]  trial;

  // compare against shifted divisor, subtract when it fits
  always_comb begin
    dv_d  = dv_i;
    trial = mi3_pkg::RemW'(dv_i.dmag) << SHIFT;
    for (int k = 0; k < 9; k++) begin
      if (dv_i.rem[k] >= trial) begin
        dv_d.rem[k]        = dv_i.rem[k] - trial;
        dv_d.quo[k][SHIFT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q <= dv_d;
    end
  end

  assign dv_o = dv_q;

endmodule

[rtl/matrix3x3_inverse_core.sv]
// top level of the pipelined 3x3 fixed-point matrix inverse
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------
//  in      | in_valid_i, in_ready_o | a00_i .. a22_i, signed Q16.16
//  out     | out_valid_o,out_ready_i| b00_o .. b22_o, determinant_o, singular_o
//
// stages: 2 cofactor, 4 determinant, 33 divider steps, 1 output.
// one request per cycle unless stalled; the divider is most of the depth.
// reset clears only the stage valid bits; data registers are not reset.
// a stall at the output freezes every stage together, so nothing is lost.
`timescale 1ns / 1ps
module matrix3x3_inverse_core #(
  parameter int unsigned FRAC_BITS = mi3_pkg::FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] a00_i,
  input  logic [31:0] a01_i,
  input  logic [31:0] a02_i,
  input  logic [31:0] a10_i,
  input  logic [31:0] a11_i,
  input  logic [31:0] a12_i,
  input  logic [31:0] a20_i,
  input  logic [31:0] a21_i,
  input  logic [31:0] a22_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] b00_o,
  output logic [31:0] b01_o,
  output logic [31:0] b02_o,
  output logic [31:0] b10_o,
  output logic [31:0] b11_o,
  output logic [31:0] b12_o,
  output logic [31:0] b20_o,
  output logic [31:0] b21_o,
  output logic [31:0] b22_o,
  output logic [31:0] determinant_o,
  output logic        singular_o
);

  localparam int unsigned Depth = mi3_pkg::PipeDepth;

  logic                                  en;
  logic [Depth-1:0]                      valid_q;
  logic [8:0][mi3_pkg::InW-1:0]          a_vec;
  logic [8:0][mi3_pkg::CofW-1:0]         cof;
  logic [2:0][mi3_pkg::InW-1:0]          row0;
  mi3_pkg::div_t                         chain [mi3_pkg::DivSteps+1];
  logic [8:0][31:0]                      b_d, b_q;
  logic [31:0]                           det_q;
  logic                                  sing_q;
  logic [mi3_pkg::QW-1:0]                qv;

  // whole pipeline advances unless the output holds an untaken result
  assign en         = !valid_q[Depth-1] || out_ready_i;
  assign in_ready_o = en;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[Depth-2:0], in_valid_i};
    end
  end

  assign a_vec = {a22_i, a21_i, a20_i, a12_i, a11_i, a10_i, a02_i, a01_i, a00_i};

  mi3_cofactor u_cof (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (a_vec),
    .cof_o  (cof),
    .row0_o (row0)
  );

  mi3_det #(
    .FRAC_BITS (FRAC_BITS)
  ) u_det (
    .clk_i  (clk_i),
    .en_i   (en),
    .cof_i  (cof),
    .row0_i (row0),
    .dv_o   (chain[0])
  );

  // divider: first step detects a quotient of 2^32 or more
  for (genvar g = 0; g < mi3_pkg::DivSteps; g++) begin : g_div
    mi3_div_step #(
      .SHIFT (mi3_pkg::DivSteps - 1 - g)
    ) u_step (
      .clk_i (clk_i),
      .en_i  (en),
      .dv_i  (chain[g]),
      .dv_o  (chain[g+1])
    );
  end

  // sign, saturation and singular zeroing of each quotient
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      qv = chain[mi3_pkg::DivSteps].quo[k];
      if (chain[mi3_pkg::DivSteps].sing) begin
        b_d[k] = '0;
      end else if (chain[mi3_pkg::DivSteps].neg[k]) begin
        if (qv > mi3_pkg::QW'(33'h0_8000_0000)) begin
          b_d[k] = 32'h8000_0000;
        end else begin
          b_d[k] = 32'(~qv + mi3_pkg::QW'(1));
        end
      end else begin
        if (qv > mi3_pkg::QW'(33'h0_7fff_ffff)) begin
          b_d[k] = 32'h7fff_ffff;
        end else begin
          b_d[k] = qv[31:0];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q    <= b_d;
      det_q  <= chain[mi3_pkg::DivSteps].det;
      sing_q <= chain[mi3_pkg::DivSteps].sing;
    end
  end

  assign out_valid_o   = valid_q[Depth-1];
  assign b00_o         = b_q[0];
  assign b01_o         = b_q[1];
  assign b02_o         = b_q[2];
  assign b10_o         = b_q[3];
  assign b11_o         = b_q[4];
  assign b12_o         = b_q[5];
  assign b20_o         = b_q[6];
  assign b21_o         = b_q[7];
  assign b22_o         = b_q[8];
  assign determinant_o = det_q;
  assign singular_o    = sing_q;

endmodule
